/* rtl/core/lph_pkg.sv */
// ============================================================================
// lph_pkg - shared definitions for the linear-probe hash table
// Sizes, operation and status codes, sequencer states and the structures
// passed between the sequencer, the slot memory and the top level.
// ============================================================================
package lph_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int DATA_W   = 32;
    localparam int FILL_W   = 11;
    localparam int ENTRY_W  = 11;
    localparam int CMP_W    = (CNT_W > FILL_W) ? CNT_W : FILL_W;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [FILL_W-1:0] FILL_RESET = FILL_W'(768);

    // Word index of each configuration register (byte address / 4).
    localparam logic REG_FILL_LIMIT = 1'b0;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REFUSED  = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] hash;
        logic [DATA_W-1:0] value;
    } t_slot;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_slot             wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        t_status            status;
        logic [ENTRY_W-1:0] entry_count;
    } t_result;

endpackage

/* rtl/core/lph_req_if.sv */
// ============================================================================
// lph_req_if - request channel of the hash table
// Carries one operation word: command, hash and value.
// ============================================================================
interface lph_req_if;

    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic signed [lph_pkg::DATA_W-1:0]   hash_key;
    logic signed [lph_pkg::DATA_W-1:0]   item_value;

    modport source (output valid, output cmd, output hash_key, output item_value,
                    input ready);
    modport sink   (input valid, input cmd, input hash_key, input item_value,
                    output ready);

endinterface

/* rtl/core/lph_rsp_if.sv */
// ============================================================================
// lph_rsp_if - response channel of the hash table
// Carries one result word: status and entry count.
// ============================================================================
interface lph_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [lph_pkg::ENTRY_W-1:0]   entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_count, output ready);

endinterface

/* rtl/core/lph_ram.sv */
// ============================================================================
// lph_ram - simple dual-port slot memory
// One write port and one read port with registered read data.
// ============================================================================
module lph_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/lph_seq.sv */
// ============================================================================
// lph_seq - probe sequencer
// Clears the slot memory after reset, then walks the probe sequence of each
// operation one slot per cycle through a single shared compare unit.
// ============================================================================
module lph_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lph_pkg::FILL_W-1:0]    i_fill_limit,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic [lph_pkg::DATA_W-1:0]    i_hash,
    input  logic [lph_pkg::DATA_W-1:0]    i_value,
    output logic                          o_done,
    output lph_pkg::t_result              o_result,
    input  logic                          i_take,
    output lph_pkg::t_mem_req             o_mem,
    input  lph_pkg::t_slot                i_rdata
);

    lph_pkg::t_state                  r_state, n_state;
    logic [lph_pkg::ADDR_W-1:0]       r_pos, n_pos;
    logic [lph_pkg::CNT_W-1:0]        r_count, n_count;
    logic [lph_pkg::ADDR_W-1:0]       r_probe, n_probe;
    lph_pkg::t_cmd                    r_cmd, n_cmd;
    logic [lph_pkg::DATA_W-1:0]       r_hash, n_hash;
    logic [lph_pkg::DATA_W-1:0]       r_value, n_value;
    lph_pkg::t_status                 r_status, n_status;

    logic [lph_pkg::DATA_W-1:0]       start_hash;
    logic                             full;
    logic                             slot_empty;
    logic                             slot_match;
    logic                             last_probe;

    // A zero hash would look like an empty slot, so it is stored as one.
    assign start_hash = (i_hash == '0) ? lph_pkg::DATA_W'(1) : i_hash;

    // The count never exceeds the capacity, so its top bit marks a full table.
    assign full = (lph_pkg::CMP_W'(r_count) >= lph_pkg::CMP_W'(i_fill_limit))
                  || r_count[lph_pkg::ADDR_W];

    assign slot_empty = (i_rdata.hash == '0);
    assign slot_match = (i_rdata.hash == r_hash) && (i_rdata.value == r_value);
    assign last_probe = &r_probe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lph_pkg::S_CLEAR;
            r_pos   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe  <= n_probe;
        r_cmd    <= n_cmd;
        r_hash   <= n_hash;
        r_value  <= n_value;
        r_status <= n_status;
    end

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_count   = r_count;
        n_probe   = r_probe;
        n_cmd     = r_cmd;
        n_hash    = r_hash;
        n_value   = r_value;
        n_status  = r_status;
        o_ready   = 1'b0;
        o_done    = 1'b0;
        o_mem.we    = 1'b0;
        o_mem.waddr = r_pos;
        o_mem.wdata = '0;
        // In the probe state the next slot is fetched ahead of the decision.
        o_mem.raddr = r_pos + 1'b1;

        unique case (r_state)
            lph_pkg::S_CLEAR: begin
                o_mem.we = 1'b1;
                n_pos    = r_pos + 1'b1;
                if (&r_pos) begin
                    n_state = lph_pkg::S_IDLE;
                end
            end
            lph_pkg::S_IDLE: begin
                o_ready     = 1'b1;
                o_mem.raddr = start_hash[lph_pkg::ADDR_W-1:0];
                if (i_valid) begin
                    n_cmd   = lph_pkg::t_cmd'(i_cmd);
                    n_hash  = start_hash;
                    n_value = i_value;
                    n_pos   = start_hash[lph_pkg::ADDR_W-1:0];
                    n_probe = '0;
                    if ((lph_pkg::t_cmd'(i_cmd) == lph_pkg::CMD_INSERT) && full) begin
                        n_status = lph_pkg::ST_REFUSED;
                        n_state  = lph_pkg::S_DONE;
                    end else begin
                        n_state = lph_pkg::S_CHECK;
                    end
                end
            end
            lph_pkg::S_CHECK: begin
                if (r_cmd == lph_pkg::CMD_INSERT) begin
                    if (slot_empty) begin
                        o_mem.we          = 1'b1;
                        o_mem.wdata.hash  = r_hash;
                        o_mem.wdata.value = r_value;
                        n_count  = r_count + 1'b1;
                        n_status = lph_pkg::ST_INSERTED;
                        n_state  = lph_pkg::S_DONE;
                    end else if (last_probe) begin
                        n_status = lph_pkg::ST_REFUSED;
                        n_state  = lph_pkg::S_DONE;
                    end else begin
                        n_pos   = r_pos + 1'b1;
                        n_probe = r_probe + 1'b1;
                    end
                end else begin
                    if (slot_empty || last_probe) begin
                        n_status = slot_match ? lph_pkg::ST_FOUND : lph_pkg::ST_MISSING;
                        n_state  = lph_pkg::S_DONE;
                    end else if (slot_match) begin
                        n_status = lph_pkg::ST_FOUND;
                        n_state  = lph_pkg::S_DONE;
                    end else begin
                        n_pos   = r_pos + 1'b1;
                        n_probe = r_probe + 1'b1;
                    end
                end
            end
            lph_pkg::S_DONE: begin
                o_done = 1'b1;
                if (i_take) begin
                    n_state = lph_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lph_pkg::S_IDLE;
            end
        endcase
    end

    assign o_result.status      = r_status;
    assign o_result.entry_count = lph_pkg::ENTRY_W'(r_count);

endmodule

/* rtl/core/linear_probe_hash_table.sv */
// ============================================================================
// linear_probe_hash_table - open-addressing hash multimap, linear probing
// Stores (hash, value) pairs in a 1024-slot memory, inserts into the first
// empty slot from the masked hash and looks pairs up along the same probe
// sequence.
// ============================================================================
//
//   Channel   Direction   Handshake             Word
//   --------  ----------  --------------------  -------------------------------
//   i_req     in          valid / ready         cmd, hash_key, item_value
//   o_rsp     out         valid / ready         status, entry_count
//   APB       in          psel/penable/pready   fill_limit at byte address 0
//
// After reset the block clears the slot memory, one slot per cycle; request
// words wait during the sweep, configuration writes do not. An operation is
// accepted when idle, then probes at most CAPACITY slots, one per cycle (the
// single read port of the slot memory sets this); a refused insert skips the
// probing. The result then waits in the sequencer until it moves into the
// output register, which lets it wait while the next word is taken.
//
module linear_probe_hash_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lph_req_if.sink                       i_req,
    lph_rsp_if.source                     o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lph_pkg::APB_AW-1:0]    paddr,
    input  logic [lph_pkg::APB_DW-1:0]    pwdata,
    output logic [lph_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    // Configuration register. The word index is bit 2 of the byte address.
    logic [lph_pkg::FILL_W-1:0] r_fill_limit;
    logic                       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == lph_pkg::REG_FILL_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_limit <= lph_pkg::FILL_RESET;
        end else if (cfg_write) begin
            r_fill_limit <= pwdata[lph_pkg::FILL_W-1:0];
        end
    end

    assign prdata = (paddr[2] == lph_pkg::REG_FILL_LIMIT)
                    ? lph_pkg::APB_DW'(r_fill_limit) : '0;

    // Sequencer and slot memory.
    lph_pkg::t_mem_req mem_req;
    lph_pkg::t_slot    mem_rdata;
    lph_pkg::t_result  seq_result;
    logic              seq_done;
    logic              take;

    lph_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fill_limit (r_fill_limit),
        .i_valid      (i_req.valid),
        .o_ready      (i_req.ready),
        .i_cmd        (i_req.cmd),
        .i_hash       (i_req.hash_key),
        .i_value      (i_req.item_value),
        .o_done       (seq_done),
        .o_result     (seq_result),
        .i_take       (take),
        .o_mem        (mem_req),
        .i_rdata      (mem_rdata)
    );

    lph_ram #(
        .DEPTH (lph_pkg::CAPACITY),
        .WIDTH ($bits(lph_pkg::t_slot)),
        .AW    (lph_pkg::ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    // Output register. A finished result moves in whenever the register is
    // empty or its current word is being taken in the same cycle.
    logic             r_out_valid, n_out_valid;
    lph_pkg::t_result r_out;

    assign take = seq_done && (!r_out_valid || o_rsp.ready);

    always_comb begin
        if (take) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= seq_result;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.entry_count = r_out.entry_count;

endmodule

/* bench/linear_probe_hash_table_tb.sv */
// ============================================================================
// linear_probe_hash_table_tb - self-checking bench for the linear-probe table
// Sends insert and lookup words with random idle gaps on both channels and
// checks every result word against a typed-in or shadow-table result. The fill
// limit register is swept over several values, including its extremes, and
// the table is driven all the way to full capacity.
// ============================================================================
module linear_probe_hash_table_tb;

    import lph_pkg::*;

    // Timing of the run.
    localparam int unsigned STALL_LIMIT = 10000;   // cycles with no handshake
    localparam int unsigned LONG_HOLD   = 200;     // long sink hold-off
    localparam int unsigned HOLD_AT     = 150;     // result count that triggers it
    localparam int unsigned TAIL_CYCLES = 24;

    localparam logic [31:0]       SLOT_MASK32 = 32'(CAPACITY - 1);
    localparam logic [APB_AW-1:0] FILL_ADDR   = APB_AW'({REG_FILL_LIMIT, 2'b00});

    // One row of the directed plan: either an operation word or a write of
    // the fill limit (held in val). Expected results are typed in only
    // where they are obvious; the rest come from the shadow table.
    typedef enum bit {
        ROW_OP,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        t_cmd               op;
        logic [31:0]        key;
        logic [31:0]        val;
        bit                 typed;
        t_status            want_status;
        logic [ENTRY_W-1:0] want_count;
    } t_row;

    localparam t_row DIRECTED [0:22] = '{
        // Empty table straight after reset.
        '{ROW_OP,  CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_MISSING,  11'd0},
        // Zero hash is stored as hash one, and matched either way.
        '{ROW_OP,  CMD_INSERT, 32'h0000_0000, 32'h0000_0005, 1'b1, ST_INSERTED, 11'd1},
        '{ROW_OP,  CMD_LOOKUP, 32'h0000_0001, 32'h0000_0005, 1'b1, ST_FOUND,    11'd1},
        '{ROW_OP,  CMD_LOOKUP, 32'h0000_0000, 32'h0000_0005, 1'b1, ST_FOUND,    11'd1},
        '{ROW_OP,  CMD_LOOKUP, 32'h0000_0001, 32'h0000_0006, 1'b1, ST_MISSING,  11'd1},
        // A duplicate pair still takes a new slot.
        '{ROW_OP,  CMD_INSERT, 32'h0000_0001, 32'h0000_0005, 1'b1, ST_INSERTED, 11'd2},
        // Extreme hashes and values; the last insert wraps past the top slot.
        '{ROW_OP,  CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, ST_INSERTED, 11'd3},
        '{ROW_OP,  CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, ST_INSERTED, 11'd4},
        '{ROW_OP,  CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_INSERTED, 11'd5},
        '{ROW_OP,  CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_FOUND,    11'd5},
        '{ROW_OP,  CMD_LOOKUP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, ST_MISSING,  11'd0},
        '{ROW_OP,  CMD_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, ST_FOUND,    11'd5},
        // Limit equal to the count refuses the next insert.
        '{ROW_CFG, CMD_INSERT, 32'h0000_0000, 32'd5,         1'b0, ST_INSERTED, 11'd0},
        '{ROW_OP,  CMD_INSERT, 32'h1234_5678, 32'h0000_0001, 1'b1, ST_REFUSED,  11'd5},
        '{ROW_OP,  CMD_LOOKUP, 32'h1234_5678, 32'h0000_0001, 1'b0, ST_MISSING,  11'd0},
        // A limit of zero refuses every insert.
        '{ROW_CFG, CMD_INSERT, 32'h0000_0000, 32'd0,         1'b0, ST_INSERTED, 11'd0},
        '{ROW_OP,  CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_REFUSED,  11'd5},
        // One more entry allowed, then refused again.
        '{ROW_CFG, CMD_INSERT, 32'h0000_0000, 32'd6,         1'b0, ST_INSERTED, 11'd0},
        '{ROW_OP,  CMD_INSERT, 32'h0000_03FF, 32'h0000_0000, 1'b1, ST_INSERTED, 11'd6},
        '{ROW_OP,  CMD_INSERT, 32'h0000_0002, 32'h0000_0009, 1'b1, ST_REFUSED,  11'd6},
        // Limit above capacity: only the capacity itself bounds the count.
        '{ROW_CFG, CMD_INSERT, 32'h0000_0000, 32'd2047,      1'b0, ST_INSERTED, 11'd0},
        '{ROW_OP,  CMD_INSERT, 32'h5555_AAAA, 32'hAAAA_5555, 1'b1, ST_INSERTED, 11'd7},
        '{ROW_OP,  CMD_LOOKUP, 32'h5555_AAAA, 32'hAAAA_5555, 1'b1, ST_FOUND,    11'd7}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    lph_req_if req_ch ();
    lph_rsp_if rsp_ch ();

    linear_probe_hash_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow of the slot memory, the entry count and the fill limit. Values
    // of empty slots stay unknown, as they are never compared.
    logic [31:0]        shadow_hash [CAPACITY];
    logic [31:0]        shadow_val  [CAPACITY];
    int unsigned        shadow_count;
    logic [FILL_W-1:0]  shadow_limit;

    // Pairs known to be stored, {hash, value}, used to aim lookups at hits.
    logic [63:0]        stored_pairs [$];
    t_result            awaited_results [$];
    t_result            head_result;

    int unsigned        words_sent;
    int unsigned        results_seen;
    int unsigned        error_count;
    int unsigned        status_tally [4];
    bit                 long_hold_due;

    // ------------------------------------------------------------------------
    // Shadow model: walks the probe sequence exactly as the block should and
    // returns the result word that the operation must produce.
    // ------------------------------------------------------------------------
    function automatic t_result run_probe(input t_cmd op, input logic [31:0] key,
                                          input logic [31:0] val);
        logic [31:0]       h;
        logic [ADDR_W-1:0] pos;
        t_result           r;
        bit                done;
        h    = (key == 32'd0) ? 32'd1 : key;
        pos  = h[ADDR_W-1:0];
        done = 1'b0;
        if (op == CMD_INSERT) begin
            r.status = ST_REFUSED;
            if (shadow_count < shadow_limit && shadow_count < CAPACITY) begin
                for (int n = 0; n < CAPACITY && !done; n++) begin
                    if (shadow_hash[pos] == 32'd0) begin
                        shadow_hash[pos] = h;
                        shadow_val[pos]  = val;
                        shadow_count++;
                        stored_pairs.push_back({h, val});
                        r.status = ST_INSERTED;
                        done     = 1'b1;
                    end else begin
                        pos = pos + 1'b1;
                    end
                end
            end
        end else begin
            r.status = ST_MISSING;
            for (int n = 0; n < CAPACITY && !done; n++) begin
                if (shadow_hash[pos] == 32'd0) begin
                    done = 1'b1;
                end else if (shadow_hash[pos] == h && shadow_val[pos] == val) begin
                    r.status = ST_FOUND;
                    done     = 1'b1;
                end else begin
                    pos = pos + 1'b1;
                end
            end
        end
        r.entry_count = ENTRY_W'(shadow_count);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        error_count++;
        $display("MISMATCH after %0d results: %s: got %0h, expected %0h",
                 results_seen, what, got, want);
    endtask

    // Idle gaps: mostly none or short, now and then long. Every fourth block
    // of 128 words runs without any gaps at all.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (((words_sent >> 7) & 3) == 1) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 99) < 85) return $urandom();
        case ($urandom_range(0, 4))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Keys are partly fully random, partly bunched round the top of the
    // table so that clusters form and probes wrap, partly zero, and partly
    // hashes that are already stored.
    function automatic logic [31:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom();
        if (r < 75) begin
            return ($urandom() & ~SLOT_MASK32)
                 | ((CAPACITY - 8 + $urandom_range(0, 11)) % CAPACITY);
        end
        if (r < 85 || stored_pairs.size() == 0) return 32'd0;
        return stored_pairs[$urandom_range(0, stored_pairs.size() - 1)][63:32];
    endfunction

    // ------------------------------------------------------------------------
    // Request side. valid is left high after a word is taken, so that a
    // back-to-back word never lowers and raises it within one step.
    // ------------------------------------------------------------------------
    task automatic send_word(input t_cmd op, input logic [31:0] key,
                             input logic [31:0] val, input bit typed,
                             input t_result typed_result);
        int unsigned gap;
        t_result     predicted;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= op;
        req_ch.hash_key   <= key;
        req_ch.item_value <= val;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        words_sent++;
        predicted = run_probe(op, key, val);
        status_tally[predicted.status]++;
        awaited_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic send_random(input bit filling);
        t_cmd        op;
        logic [31:0] key;
        logic [31:0] val;
        logic [63:0] pair;
        int unsigned r;
        int unsigned slot;
        int unsigned miss_pct;
        r   = $urandom_range(0, 99);
        key = pick_key();
        val = pick_value();
        if (filling) begin
            // Aim inserts straight at empty slots so the table fills cheaply;
            // once full, misses are kept rare as each one walks every slot.
            miss_pct = (shadow_count < CAPACITY) ? 10 : 3;
            if (shadow_count < CAPACITY && r < 90) begin
                op   = CMD_INSERT;
                slot = $urandom_range(0, CAPACITY - 1);
                while (shadow_hash[slot] != 32'd0) slot = (slot + 1) % CAPACITY;
                key = ($urandom() & ~SLOT_MASK32) | 32'(slot);
            end else begin
                op = CMD_LOOKUP;
                if (stored_pairs.size() != 0 && $urandom_range(0, 99) >= miss_pct) begin
                    pair = stored_pairs[$urandom_range(0, stored_pairs.size() - 1)];
                    key  = pair[63:32];
                    val  = pair[31:0];
                end
            end
        end else if (r < 45) begin
            op = CMD_INSERT;
        end else begin
            op = CMD_LOOKUP;
            r  = $urandom_range(0, 99);
            if (stored_pairs.size() != 0 && r < 70) begin
                pair = stored_pairs[$urandom_range(0, stored_pairs.size() - 1)];
                key  = pair[63:32];
                // Exact pair most of the time, else same hash, other value.
                if (r < 50) val = pair[31:0];
            end
        end
        send_word(op, key, val, 1'b0, '0);
    endtask

    // Lower valid and hold off until every awaited result has come back.
    task automatic wait_drain();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Register port.
    // ------------------------------------------------------------------------
    task automatic apb_read(input logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the fill limit with random bits above the field, then read back.
    task automatic set_fill_limit(input logic [FILL_W-1:0] lim);
        logic [APB_DW-1:0] rd;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FILL_ADDR;
        pwdata  <= ($urandom() & ~APB_DW'({FILL_W{1'b1}})) | APB_DW'(lim);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        shadow_limit = lim;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apb_read(FILL_ADDR, rd);
        if (rd[FILL_W-1:0] !== lim) begin
            note_mismatch("fill limit read-back", 64'(rd), 64'(lim));
        end
    endtask

    task automatic run_phase(input logic [FILL_W-1:0] lim, input int unsigned n_words,
                             input bit filling);
        wait_drain();
        set_fill_limit(lim);
        for (int i = 0; i < n_words || (filling && shadow_count < CAPACITY); i++) begin
            send_random(filling);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, plus one long hold-off partway
    // through so that the output register and the input both stall.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (long_hold_due) begin
                    long_hold_due = 1'b0;
                    hold_left     = LONG_HOLD;
                end else begin
                    hold_left = pick_gap();
                end
            end
        end
    end

    // Each result word is compared with the oldest awaited one.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                note_mismatch("result with nothing awaited",
                              64'({rsp_ch.status, rsp_ch.entry_count}), '0);
            end else begin
                head_result = awaited_results.pop_front();
                if (rsp_ch.status !== head_result.status) begin
                    note_mismatch("status", 64'(rsp_ch.status), 64'(head_result.status));
                end
                if (rsp_ch.entry_count !== head_result.entry_count) begin
                    note_mismatch("entry count", 64'(rsp_ch.entry_count),
                                  64'(head_result.entry_count));
                end
            end
            if (results_seen == HOLD_AT) long_hold_due = 1'b1;
        end
    end

    // The watchdog allows for the clearing sweep after reset, a lookup that
    // walks the whole full table and the long sink hold-off, many times over.
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
                || (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timed out: no word moved for %0d cycles, %0d results outstanding.",
                 STALL_LIMIT, awaited_results.size());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed plan, then random phases over a range of
    // fill limits, ending with a completely full table.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [APB_DW-1:0] rd;
        t_result           typed_result;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.cmd        = CMD_INSERT;
        req_ch.hash_key   = '0;
        req_ch.item_value = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        words_sent        = 0;
        results_seen      = 0;
        error_count       = 0;
        long_hold_due     = 1'b0;
        shadow_count      = 0;
        shadow_limit      = FILL_RESET;
        for (int s = 0; s < CAPACITY; s++) shadow_hash[s] = 32'd0;
        for (int s = 0; s < 4; s++) status_tally[s] = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The register comes out of reset at three quarters of capacity.
        apb_read(FILL_ADDR, rd);
        if (rd[FILL_W-1:0] !== FILL_RESET) begin
            note_mismatch("fill limit at reset", 64'(rd), 64'(FILL_RESET));
        end

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                wait_drain();
                set_fill_limit(DIRECTED[i].val[FILL_W-1:0]);
            end else begin
                typed_result.status      = DIRECTED[i].want_status;
                typed_result.entry_count = DIRECTED[i].want_count;
                send_word(DIRECTED[i].op, DIRECTED[i].key, DIRECTED[i].val,
                          DIRECTED[i].typed, typed_result);
            end
        end

        run_phase(FILL_W'(300), 350, 1'b0);
        run_phase(FILL_W'(1), 120, 1'b0);
        run_phase(FILL_W'(700), 350, 1'b0);
        run_phase(FILL_W'(CAPACITY), 620, 1'b1);
        run_phase({FILL_W{1'b1}}, 60, 1'b0);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d words: %0d inserted, %0d refused, %0d found, %0d missing.",
                 words_sent, status_tally[ST_INSERTED], status_tally[ST_REFUSED],
                 status_tally[ST_FOUND], status_tally[ST_MISSING]);
        $display("Fill limit swept from 0 to 2047; table filled to %0d of %0d slots.",
                 shadow_count, CAPACITY);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches in all.", error_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* linear_probe_hash_table.f */
rtl/core/lph_pkg.sv
rtl/core/lph_req_if.sv
rtl/core/lph_rsp_if.sv
rtl/core/lph_ram.sv
rtl/core/lph_seq.sv
rtl/core/linear_probe_hash_table.sv
bench/linear_probe_hash_table_tb.sv
